// ----- rtl/core/nco_cfs_pkg.sv -----
package nco_cfs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int STEP_BITS = 32;
    localparam int PHASE_BITS_DEF = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] shifted_re;
        logic signed [SAMPLE_BITS-1:0] shifted_im;
    } out_item_t;

    typedef struct packed {
        logic swap;
        logic neg_sin;
        logic neg_cos;
    } rot_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ----- rtl/core/nco_cfs_front.sv -----
module nco_cfs_front #(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [nco_cfs_pkg::STEP_BITS-1:0]   cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  nco_cfs_pkg::in_item_t               in_data,
    output logic                                push_valid,
    input  logic                                push_ready,
    output nco_cfs_pkg::rot_ctl_t               push_ctl,
    output logic [TABLE_ADDR_BITS-1:0]          push_idx,
    output nco_cfs_pkg::in_item_t               push_sample
);
    import nco_cfs_pkg::*;

    logic signed [STEP_BITS-1:0]  step_reg;
    logic [PHASE_BITS-1:0]        phase_reg;
    logic [PHASE_BITS-1:0]        phase_next;
    logic [TABLE_ADDR_BITS+1:0]   top_bits;
    logic [1:0]                   quad;

    assign top_bits = phase_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
    assign quad     = top_bits[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];

    assign in_ready         = push_ready;
    assign push_valid       = in_valid;
    assign push_sample      = in_data;
    assign push_idx         = top_bits[TABLE_ADDR_BITS-1:0];
    assign push_ctl.swap    = quad[0];
    assign push_ctl.neg_sin = quad[1];
    assign push_ctl.neg_cos = quad[1] ^ quad[0];

    assign phase_next = phase_reg + PHASE_BITS'(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_reg <= signed'(cfg_wr_data);
            end
            // advance phase once per transfer
            if (in_valid && in_ready)
            begin
                phase_reg <= phase_next;
            end
        end
    end

endmodule

// ----- rtl/core/nco_cfs_queue.sv -----
module nco_cfs_queue #(
    parameter int WIDTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    output logic                        push_ready,
    input  logic [WIDTH-1:0]            push_data,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output logic [WIDTH-1:0]            pop_data,
    output nco_cfs_pkg::queue_stat_t    stat
);
    import nco_cfs_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign pop_data   = entry_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/nco_cfs_back.sv -----
module nco_cfs_back #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  nco_cfs_pkg::rot_ctl_t       pop_ctl,
    input  logic [TABLE_ADDR_BITS-1:0]  pop_idx,
    input  nco_cfs_pkg::in_item_t       pop_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output nco_cfs_pkg::out_item_t      out_data
);
    import nco_cfs_pkg::*;

    localparam int TBL_LEN   = 1 << TABLE_ADDR_BITS;
    localparam int ADDR_B_W  = TABLE_ADDR_BITS + 1;
    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int AMP       = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int Q_BITS    = SUM_BITS - MAG_BITS + 1;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_RND     = 64'd1 << 29;

    typedef logic [TBL_LEN:0][MAG_BITS-1:0] rom_t;

    function automatic rom_t build_rom();
        rom_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        t = '0;
        for (int k = 0; k <= TBL_LEN; k++)
        begin
            x    = (Q30_HALF_PI * 64'(k) + 64'(TBL_LEN / 2)) >> TABLE_ADDR_BITS;
            x2   = (x * x + Q30_RND) >> 30;
            sum  = x;
            term = ((x * x2 + Q30_RND) >> 30) / 64'd6;
            sum  = (sum >= term) ? sum - term : '0;
            term = ((term * x2 + Q30_RND) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2 + Q30_RND) >> 30) / 64'd42;
            sum  = (sum >= term) ? sum - term : '0;
            term = ((term * x2 + Q30_RND) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2 + Q30_RND) >> 30) / 64'd110;
            sum  = (sum >= term) ? sum - term : '0;
            term = ((term * x2 + Q30_RND) >> 30) / 64'd156;
            sum  = sum + term;
            e    = (sum * 64'(AMP) + Q30_RND) >> 30;
            if (e > 64'(AMP))
            begin
                e = 64'(AMP);
            end
            t[k] = MAG_BITS'(e);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS:0]   biased;
        logic signed [Q_BITS-1:0]   q;
        logic signed [SAMPLE_BITS-1:0] r;
        biased = (SUM_BITS + 1)'(v) + (SUM_BITS + 1)'(1 << (SAMPLE_BITS - 2));
        q      = Q_BITS'(biased >>> MAG_BITS);
        if (q > Q_BITS'(AMP))
        begin
            r = SAMPLE_BITS'(AMP);
        end
        else if (q < -Q_BITS'(AMP) - Q_BITS'(1))
        begin
            r = -SAMPLE_BITS'(AMP) - SAMPLE_BITS'(1);
        end
        else
        begin
            r = SAMPLE_BITS'(q);
        end
        return r;
    endfunction

    logic                           adv;
    logic [ADDR_B_W-1:0]            addr_a;
    logic [ADDR_B_W-1:0]            addr_b;

    logic                           s1_valid_reg;
    rot_ctl_t                       s1_ctl_reg;
    in_item_t                       s1_sample_reg;
    logic [MAG_BITS-1:0]            s1_mag_a_reg;
    logic [MAG_BITS-1:0]            s1_mag_b_reg;

    logic [MAG_BITS-1:0]            mag_sin;
    logic [MAG_BITS-1:0]            mag_cos;
    logic signed [SAMPLE_BITS-1:0]  sin_pos;
    logic signed [SAMPLE_BITS-1:0]  cos_pos;
    logic signed [SAMPLE_BITS-1:0]  sin_val;
    logic signed [SAMPLE_BITS-1:0]  cos_val;

    logic                           s2_valid_reg;
    logic signed [PROD_BITS-1:0]    s2_ac_reg;
    logic signed [PROD_BITS-1:0]    s2_bs_reg;
    logic signed [PROD_BITS-1:0]    s2_as_reg;
    logic signed [PROD_BITS-1:0]    s2_bc_reg;

    logic signed [SUM_BITS-1:0]     re_sum;
    logic signed [SUM_BITS-1:0]     im_sum;

    logic                           out_valid_reg;
    out_item_t                      out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign addr_a    = {1'b0, pop_idx};
    assign addr_b    = ADDR_B_W'(TBL_LEN) - {1'b0, pop_idx};

    assign mag_sin = s1_ctl_reg.swap ? s1_mag_b_reg : s1_mag_a_reg;
    assign mag_cos = s1_ctl_reg.swap ? s1_mag_a_reg : s1_mag_b_reg;
    assign sin_pos = signed'({1'b0, mag_sin});
    assign cos_pos = signed'({1'b0, mag_cos});
    assign sin_val = s1_ctl_reg.neg_sin ? -sin_pos : sin_pos;
    assign cos_val = s1_ctl_reg.neg_cos ? -cos_pos : cos_pos;

    assign re_sum = SUM_BITS'(s2_ac_reg) - SUM_BITS'(s2_bs_reg);
    assign im_sum = SUM_BITS'(s2_as_reg) + SUM_BITS'(s2_bc_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // hold all stages while the output waits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg    <= pop_ctl;
            s1_sample_reg <= pop_sample;
            s1_mag_a_reg  <= SINE_ROM[addr_a];
            s1_mag_b_reg  <= SINE_ROM[addr_b];

            s2_ac_reg <= s1_sample_reg.sample_re * cos_val;
            s2_bs_reg <= s1_sample_reg.sample_im * sin_val;
            s2_as_reg <= s1_sample_reg.sample_re * sin_val;
            s2_bc_reg <= s1_sample_reg.sample_im * cos_val;

            out_data_reg.shifted_re <= round_sat(re_sum);
            out_data_reg.shifted_im <= round_sat(im_sum);
        end
    end

endmodule

// ----- rtl/core/nco_complex_frequency_shifter_unit.sv -----
// Channel   Signals                          Direction  Carries
// config    cfg_wr_en, cfg_wr_data           in         phase step per sample
// input     in_valid, in_ready, in_data      in         one IQ sample per transfer
// output    out_valid, out_ready, out_data   out        one rotated IQ sample per transfer
//
// Sustains one sample per cycle while the output is not stalled; each accepted sample passes
// the queue entry, the sine table read, the multiply stage and the rounded output register.
// Reset clears the phase and the step; no clearing pass, the table is constant.
// An output stall holds the back pipeline; the two-entry queue then fills and in_ready drops.
module nco_complex_frequency_shifter_unit #(
    parameter int PHASE_BITS = nco_cfs_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = nco_cfs_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [nco_cfs_pkg::STEP_BITS-1:0]   cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  nco_cfs_pkg::in_item_t               in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output nco_cfs_pkg::out_item_t              out_data
);
    import nco_cfs_pkg::*;

    localparam int Q_WIDTH = $bits(rot_ctl_t) + TABLE_ADDR_BITS + $bits(in_item_t);

    logic                        q_push_valid;
    logic                        q_push_ready;
    rot_ctl_t                    push_ctl;
    logic [TABLE_ADDR_BITS-1:0]  push_idx;
    in_item_t                    push_sample;
    logic                        q_pop_valid;
    logic                        q_pop_ready;
    rot_ctl_t                    pop_ctl;
    logic [TABLE_ADDR_BITS-1:0]  pop_idx;
    in_item_t                    pop_sample;
    logic [Q_WIDTH-1:0]          q_push_data;
    logic [Q_WIDTH-1:0]          q_pop_data;
    queue_stat_t                 q_stat;

    assign q_push_data = {push_ctl, push_idx, push_sample};
    assign {pop_ctl, pop_idx, pop_sample} = q_pop_data;

    nco_cfs_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .push_valid  (q_push_valid),
        .push_ready  (q_push_ready),
        .push_ctl    (push_ctl),
        .push_idx    (push_idx),
        .push_sample (push_sample)
    );

    nco_cfs_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .stat       (q_stat)
    );

    nco_cfs_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_ctl    (pop_ctl),
        .pop_idx    (pop_idx),
        .pop_sample (pop_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

`ifndef SYNTH
    a_accept_lands_in_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_stat.empty
    ) else $error("accepted sample missing from queue");

    a_no_pop_on_output_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(q_pop_valid && q_pop_ready)
    ) else $error("queue popped while output stalled");

    a_queue_full_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_stat.full && !(q_pop_valid && q_pop_ready)) |=> !in_ready
    ) else $error("input ready while queue stays full");
`endif

endmodule

// ----- sim/nco_complex_frequency_shifter_unit_tb.sv -----
`timescale 1ns / 100ps

module nco_complex_frequency_shifter_unit_tb;
    import nco_cfs_pkg::*;

    class mixer_scoreboard;
        localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
        localparam longint unsigned Q30_ROUND = 64'd1 << 29;
        localparam longint AMPLITUDE = 32767;

        longint sine_quarter [0:1024];
        bit [31:0] phase;
        bit [31:0] step;
        out_item_t expected_shifted [$];
        int mismatches;
        int samples_seen;
        int results_checked;

        function new();
            phase = '0;
            step = '0;
            mismatches = 0;
            samples_seen = 0;
            results_checked = 0;
            build_sine_quarter();
        endfunction

        function void build_sine_quarter();
            longint unsigned x, x2, term, acc, e;
            for (int k = 0; k <= 1024; k++) begin
                x = (HALF_PI_Q30 * longint'(k) + 64'd512) >> 10;
                x2 = (x * x + Q30_ROUND) >> 30;
                term = x;
                acc = x;
                for (int n = 1; n <= 6; n++) begin
                    term = ((term * x2 + Q30_ROUND) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        acc = (acc >= term) ? acc - term : 64'd0;
                    else
                        acc = acc + term;
                end
                e = (acc * 64'd32767 + Q30_ROUND) >> 30;
                if (e > 64'd32767)
                    e = 64'd32767;
                sine_quarter[k] = longint'(e);
            end
        endfunction

        function longint sine_of(bit [1:0] quad, bit [9:0] idx);
            case (quad)
                2'd0: return sine_quarter[idx];
                2'd1: return sine_quarter[1024 - idx];
                2'd2: return -sine_quarter[idx];
                default: return -sine_quarter[1024 - idx];
            endcase
        endfunction

        function logic signed [15:0] round_saturate(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > AMPLITUDE)
                r = AMPLITUDE;
            else if (r < -AMPLITUDE - 1)
                r = -AMPLITUDE - 1;
            return r[15:0];
        endfunction

        function out_item_t rotate_sample(in_item_t s);
            out_item_t r;
            bit [11:0] top;
            bit [1:0] cos_quad;
            longint sn, cs, a, b;
            top = phase[31:20];
            cos_quad = top[11:10] + 2'd1;
            sn = sine_of(top[11:10], top[9:0]);
            cs = sine_of(cos_quad, top[9:0]);
            a = longint'(s.sample_re);
            b = longint'(s.sample_im);
            r.shifted_re = round_saturate(a * cs - b * sn);
            r.shifted_im = round_saturate(a * sn + b * cs);
            phase = phase + step;
            return r;
        endfunction

        function void set_step(bit [31:0] value);
            step = value;
        endfunction

        function int pending();
            return expected_shifted.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task note_input(in_item_t s);
            samples_seen++;
            expected_shifted.push_back(rotate_sample(s));
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_shifted.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result re=%0d im=%0d",
                    got.shifted_re, got.shifted_im));
                return;
            end
            want = expected_shifted.pop_front();
            results_checked++;
            if (got.shifted_re !== want.shifted_re)
                report_mismatch($sformatf("result %0d shifted_re got %0d want %0d",
                    results_checked, got.shifted_re, want.shifted_re));
            if (got.shifted_im !== want.shifted_im)
                report_mismatch($sformatf("result %0d shifted_im got %0d want %0d",
                    results_checked, got.shifted_im, want.shifted_im));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [STEP_BITS-1:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    int send_idle;
    int recv_stall;
    int step_writes;
    mixer_scoreboard sb;

    logic [31:0] corner_samples [8] = '{32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF,
        32'h7FFF_8000, 32'h0000_0000, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'h4000_C000};
    logic [31:0] fixed_steps [6] = '{32'h0000_0000, 32'h0010_0000, 32'hFFF0_0000,
        32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};

    always #4 clk = ~clk;

    nco_complex_frequency_shifter_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    task automatic send_sample(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained(input int settle);
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_step(input logic [31:0] value);
        in_valid <= 1'b0;
        wait_drained(4);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_step(value);
        step_writes++;
    endtask

    function automatic in_item_t pick_sample();
        in_item_t s;
        s = $urandom();
        case ($urandom_range(0, 9))
            6:
            begin
                s.sample_re = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                s.sample_im = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            7:
            begin
                s.sample_re = 16'(int'($urandom_range(0, 31)) - 16);
                s.sample_im = 16'(int'($urandom_range(0, 31)) - 16);
            end
            8: s.sample_re = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            9:
            begin
                s.sample_re = 16'(int'($urandom_range(0, 2)) - 1);
                s.sample_im = 16'(int'($urandom_range(0, 2)) - 1);
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_corners(input int first, input int count);
        for (int i = first; i < first + count; i++)
            send_sample(in_item_t'(corner_samples[i]));
    endtask

    initial
    begin
        sb = new();
        send_idle = 0;
        recv_stall = 0;
        step_writes = 0;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset step of zero: plain pass at 0 rad
        send_corners(0, 8);
        // eighth turn: full-scale inputs saturate
        write_step(32'h2000_0000);
        send_corners(0, 8);
        write_step(32'h8000_0000);
        send_corners(0, 4);
        write_step(32'h7FFF_FFFF);
        send_corners(0, 2);
        write_step(32'hFFFF_FFFF);
        send_corners(2, 2);

        for (int seg = 0; seg < 14; seg++)
        begin
            if (seg < 6)
                write_step(fixed_steps[seg]);
            else if (seg % 2 == 0)
                write_step($urandom());
            else
                write_step($urandom_range(0, 32'h00FF_FFFF) | ($urandom_range(0, 1) << 31));
            case (seg % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 65;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 65;
                end
                default:
                begin
                    send_idle = 17;
                    recv_stall = 17;
                end
            endcase
            for (int i = 0; i < 100; i++)
                send_sample(pick_sample());
        end
        in_valid <= 1'b0;
        recv_stall = 0;
        wait_drained(10);

        $display("Covered %0d samples and %0d checked results over %0d step settings,",
            sb.samples_seen, sb.results_checked, step_writes);
        $display("with corner inputs, saturation, extreme steps and four idle patterns.");
        if (sb.mismatches == 0)
            $display("nco_complex_frequency_shifter_unit_tb OK");
        else
            $display("nco_complex_frequency_shifter_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("nco_complex_frequency_shifter_unit_tb NOT OK");
        $finish;
    end
endmodule
